FILE: rtl/skyfs_pkg.sv
// Package for the skyline forward-substitution block.
// Holds number formats, sizes, sequencer states and magnitude helpers.
// No dependencies; used by the top level and its checker.
package skyfs_pkg;

   // Number format and sizes
   localparam int VALUE_BITS    = 32;
   localparam int FRACTION_BITS = 16;
   localparam int ACC_BITS      = 64;
   localparam int PROD_BITS     = 2 * VALUE_BITS;
   localparam int QPROD_BITS    = PROD_BITS - FRACTION_BITS;
   localparam int BLOCK_BITS    = 16;

   // Solution memory and row counter
   localparam int MAX_ROWS = 1024;
   localparam int ROW_BITS = $clog2(MAX_ROWS);

   // Profile position counter, saturating
   localparam int OFFSET_BITS = 11;
   localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = {OFFSET_BITS{1'b1}};

   // Divider: one quotient bit per step over the shifted numerator
   localparam int DIV_STEPS = ACC_BITS + FRACTION_BITS;
   localparam int STEP_BITS = $clog2(DIV_STEPS);

   // Quotient clip limits, in the rounded quotient width
   localparam int QR_BITS = VALUE_BITS + 2;
   localparam logic [QR_BITS-1:0] NEG_LIMIT = QR_BITS'(1) << (VALUE_BITS - 1);
   localparam logic [QR_BITS-1:0] POS_LIMIT = NEG_LIMIT - QR_BITS'(1);

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_ACC,
      ST_FIN,
      ST_DIV,
      ST_RND
   } state_type;

   // Magnitude of a signed value word
   function automatic logic [VALUE_BITS-1:0] mag_value(input logic [VALUE_BITS-1:0] v);
      return v[VALUE_BITS-1] ? (~v + VALUE_BITS'(1)) : v;
   endfunction

   // Magnitude of a signed accumulator word
   function automatic logic [ACC_BITS-1:0] mag_acc(input logic [ACC_BITS-1:0] v);
      return v[ACC_BITS-1] ? (~v + ACC_BITS'(1)) : v;
   endfunction

endpackage

FILE: rtl/skyline_forward_substitution.sv
// Top level of the skyline lower-triangular forward-substitution block.
// Holds the sequencer, multiplier, restoring divider and solution memory.
// Depends on skyfs_pkg.
//
//   channel  direction  beat contents
//   req_*    in         one profile entry: coefficient, rhs, row flags, block
//   rsp_*    out        one solved row: solution, row, block, final, saturated
//
// A row_start entry, or a skipped coefficient, is handled in the idle state; a used
// coefficient goes through memory read, 32x32 multiply, round and saturating add.
// A row_end entry then goes through setup, 80 steps of the bit-serial divider and
// round when its diagonal is positive; with a diagonal that is not positive, setup and round.
// Reset clears the control state only; the solution memory is not cleared.
// A result waits in the output register; the block stalls in its round step only
// when the previous result has not been taken yet.
module skyline_forward_substitution
   import skyfs_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [VALUE_BITS-1:0] req_entry_value,
   input  logic signed [VALUE_BITS-1:0] req_rhs_value,
   input  logic                         req_row_start,
   input  logic                         req_row_end,
   input  logic                         req_last_row,
   input  logic        [BLOCK_BITS-1:0] req_block_index,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [VALUE_BITS-1:0] rsp_solution,
   output logic        [ROW_BITS-1:0]   rsp_row_number,
   output logic        [BLOCK_BITS-1:0] rsp_block_echo,
   output logic                         rsp_final_row,
   output logic                         rsp_saturated
);

   // Sequencer
   state_type state_ff, state_in;

   // Row state
   logic [ROW_BITS-1:0]    row_ff, row_in;
   logic [OFFSET_BITS-1:0] offset_ff, offset_in;
   logic [ACC_BITS-1:0]    acc_ff, acc_in;
   logic [VALUE_BITS-1:0]  diag_ff, diag_in;
   logic                   ovf_ff, ovf_in;

   // Captured beat
   logic [VALUE_BITS-1:0]  entry_ff, entry_in;
   logic                   end_ff, end_in;
   logic                   last_ff, last_in;
   logic [BLOCK_BITS-1:0]  block_ff, block_in;

   // Multiplier
   logic [PROD_BITS-1:0]   prod_ff, prod_in;
   logic                   pneg_ff, pneg_in;

   // Divider
   logic [ACC_BITS-1:0]    num_ff, num_in;
   logic [VALUE_BITS-2:0]  rem_ff, rem_in;
   logic [VALUE_BITS:0]    quo_ff, quo_in;
   logic                   big_ff, big_in;
   logic                   neg_ff, neg_in;
   logic [STEP_BITS-1:0]   step_ff, step_in;

   // Output register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [VALUE_BITS-1:0]  sol_ff, sol_in;
   logic [ROW_BITS-1:0]    rnum_ff, rnum_in;
   logic [BLOCK_BITS-1:0]  becho_ff, becho_in;
   logic                   final_ff, final_in;
   logic                   sat_ff, sat_in;

   // Solution memory
   logic [VALUE_BITS-1:0]  solution_store [MAX_ROWS];
   logic [VALUE_BITS-1:0]  rd_data_ff;
   logic [ROW_BITS-1:0]    rd_addr;
   logic                   rd_en;
   logic                   mem_we;

   // Decode
   logic                   accept;
   logic                   open_row;
   logic                   use_coef;
   logic                   out_free;
   logic                   diag_pos;
   logic                   div_last;

   // Datapath intermediates
   logic [PROD_BITS-1:0]   prod_rnd;
   logic [QPROD_BITS-1:0]  qprod;
   logic [ACC_BITS:0]      delta;
   logic [ACC_BITS:0]      sum;
   logic [VALUE_BITS-1:0]  div_trial;
   logic                   div_ge;
   logic [VALUE_BITS-1:0]  div_sub;
   logic                   rnd_up;
   logic [QR_BITS-1:0]     qr;
   logic                   div_clip;
   logic [QR_BITS-1:0]     sol_mag;
   logic [QR_BITS-1:0]     sol_neg;
   logic [VALUE_BITS-1:0]  sol_word;
   logic                   sol_clip;

   // Decode the incoming beat and the row state
   assign accept   = req_valid && req_ready;
   assign open_row = (offset_ff != '0);
   assign use_coef = !req_row_start && open_row && (offset_ff != OFFSET_MAX) &&
                     ({{(OFFSET_BITS-ROW_BITS){1'b0}}, row_ff} >= offset_ff);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign diag_pos = !diag_ff[VALUE_BITS-1] && (diag_ff != '0);
   assign div_last = (step_ff == STEP_BITS'(DIV_STEPS - 1));
   assign rd_addr  = row_ff - offset_ff[ROW_BITS-1:0];

   // Round the product and form the signed term to add
   assign prod_rnd = prod_ff + (PROD_BITS'(1) << (FRACTION_BITS - 1));
   assign qprod    = prod_rnd[PROD_BITS-1:FRACTION_BITS];
   assign delta    = pneg_ff ? {{(ACC_BITS+1-QPROD_BITS){1'b0}}, qprod}
                             : ((ACC_BITS+1)'(0) - {{(ACC_BITS+1-QPROD_BITS){1'b0}}, qprod});
   assign sum      = {acc_ff[ACC_BITS-1], acc_ff} + delta;

   // One restoring divider step
   assign div_trial = {rem_ff, num_ff[ACC_BITS-1]};
   assign div_ge    = (div_trial >= {1'b0, diag_ff[VALUE_BITS-2:0]});
   assign div_sub   = div_trial - {1'b0, diag_ff[VALUE_BITS-2:0]};

   // Round the quotient and clip it to the value range
   assign rnd_up   = ({rem_ff, 1'b0} >= {1'b0, diag_ff[VALUE_BITS-2:0]});
   assign qr       = {1'b0, quo_ff} + {{(QR_BITS-1){1'b0}}, rnd_up};
   assign div_clip = big_ff || (neg_ff ? (qr > NEG_LIMIT) : (qr > POS_LIMIT));
   assign sol_mag  = div_clip ? (neg_ff ? NEG_LIMIT : POS_LIMIT) : qr;
   assign sol_neg  = QR_BITS'(0) - sol_mag;
   assign sol_word = !diag_pos ? '0 : (neg_ff ? sol_neg[VALUE_BITS-1:0]
                                              : sol_mag[VALUE_BITS-1:0]);
   assign sol_clip = ovf_ff || (diag_pos && div_clip);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (use_coef) begin
                  state_in = ST_MUL;
               end else if (req_row_end && (req_row_start || open_row)) begin
                  state_in = ST_FIN;
               end
            end
         end
         ST_MUL: state_in = ST_ACC;
         ST_ACC: state_in = end_ff ? ST_FIN : ST_IDLE;
         ST_FIN: state_in = diag_pos ? ST_DIV : ST_RND;
         ST_DIV: state_in = div_last ? ST_RND : ST_DIV;
         ST_RND: state_in = out_free ? ST_IDLE : ST_RND;
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs and datapath next values
   always_comb begin
      req_ready    = 1'b0;
      rd_en        = 1'b0;
      mem_we       = 1'b0;
      row_in       = row_ff;
      offset_in    = offset_ff;
      acc_in       = acc_ff;
      diag_in      = diag_ff;
      ovf_in       = ovf_ff;
      entry_in     = entry_ff;
      end_in       = end_ff;
      last_in      = last_ff;
      block_in     = block_ff;
      prod_in      = prod_ff;
      pneg_in      = pneg_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      big_in       = big_ff;
      neg_in       = neg_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      sol_in       = sol_ff;
      rnum_in      = rnum_ff;
      becho_in     = becho_ff;
      final_in     = final_ff;
      sat_in       = sat_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (accept) begin
               entry_in = req_entry_value;
               end_in   = req_row_end;
               last_in  = req_last_row;
               block_in = req_block_index;
               rd_en    = use_coef;
               if (req_row_start) begin
                  // open a new row, or restart the open one
                  diag_in   = req_entry_value;
                  acc_in    = {{(ACC_BITS-VALUE_BITS){req_rhs_value[VALUE_BITS-1]}},
                               req_rhs_value};
                  ovf_in    = 1'b0;
                  offset_in = OFFSET_BITS'(1);
               end else if (open_row && (offset_ff != OFFSET_MAX)) begin
                  // advance the profile position
                  offset_in = offset_ff + OFFSET_BITS'(1);
               end
            end
         end
         ST_MUL: begin
            prod_in = PROD_BITS'(mag_value(entry_ff)) * PROD_BITS'(mag_value(rd_data_ff));
            pneg_in = entry_ff[VALUE_BITS-1] ^ rd_data_ff[VALUE_BITS-1];
         end
         ST_ACC: begin
            // subtract the product, clip to the accumulator range
            if (sum[ACC_BITS] != sum[ACC_BITS-1]) begin
               acc_in = sum[ACC_BITS] ? {1'b1, {(ACC_BITS-1){1'b0}}}
                                      : {1'b0, {(ACC_BITS-1){1'b1}}};
               ovf_in = 1'b1;
            end else begin
               acc_in = sum[ACC_BITS-1:0];
            end
         end
         ST_FIN: begin
            num_in  = mag_acc(acc_ff);
            neg_in  = acc_ff[ACC_BITS-1];
            rem_in  = '0;
            quo_in  = '0;
            big_in  = 1'b0;
            step_in = '0;
         end
         ST_DIV: begin
            rem_in  = div_ge ? div_sub[VALUE_BITS-2:0] : div_trial[VALUE_BITS-2:0];
            quo_in  = {quo_ff[VALUE_BITS-1:0], div_ge};
            big_in  = big_ff || quo_ff[VALUE_BITS];
            num_in  = num_ff << 1;
            step_in = step_ff + STEP_BITS'(1);
         end
         ST_RND: begin
            if (out_free) begin
               // store and emit the solution, close the row
               mem_we       = 1'b1;
               rsp_valid_in = 1'b1;
               sol_in       = sol_word;
               rnum_in      = row_ff;
               becho_in     = block_ff;
               final_in     = last_ff;
               sat_in       = sol_clip;
               row_in       = last_ff ? '0 : row_ff + ROW_BITS'(1);
               offset_in    = '0;
               acc_in       = '0;
               ovf_in       = 1'b0;
            end
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         row_ff       <= '0;
         offset_ff    <= '0;
         acc_ff       <= '0;
         diag_ff      <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         offset_ff    <= offset_in;
         acc_ff       <= acc_in;
         diag_ff      <= diag_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      end_ff   <= end_in;
      last_ff  <= last_in;
      block_ff <= block_in;
      prod_ff  <= prod_in;
      pneg_ff  <= pneg_in;
      num_ff   <= num_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      big_ff   <= big_in;
      neg_ff   <= neg_in;
      step_ff  <= step_in;
      sol_ff   <= sol_in;
      rnum_ff  <= rnum_in;
      becho_ff <= becho_in;
      final_ff <= final_in;
      sat_ff   <= sat_in;
   end

   // Solution memory: one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         solution_store[row_ff] <= sol_word;
      end
      if (rd_en) begin
         rd_data_ff <= solution_store[rd_addr];
      end
   end

   // Drive the result channel
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_solution   = sol_ff;
   assign rsp_row_number = rnum_ff;
   assign rsp_block_echo = becho_ff;
   assign rsp_final_row  = final_ff;
   assign rsp_saturated  = sat_ff;

endmodule

FILE: rtl/skyfs_checker.sv
// Port-level checker for the skyline forward-substitution block.
// Bound to the top level below; depends on skyfs_pkg.
module skyfs_checker
   import skyfs_pkg::*;
(
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         req_row_start,
   input logic                         req_row_end,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic signed [VALUE_BITS-1:0] rsp_solution,
   input logic        [ROW_BITS-1:0]   rsp_row_number
);

   // Hold a stalled result beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_solution) &&
                                  $stable(rsp_row_number))
      else $error("result beat dropped or changed while stalled");

   // Come out of reset idle and empty
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("block not idle after reset");

   // A diagonal-only row goes straight into its setup step and holds the input channel
   a_diag_row_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_row_start && req_row_end |=> !req_ready)
      else $error("single-entry row did not start its division");

   // A row opener without row end leaves the input channel ready again
   a_start_quick: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_row_start && !req_row_end |=> req_ready)
      else $error("row opener held the input channel");

   // A new result only comes out of a busy cycle
   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared while the block was idle");

endmodule

bind skyline_forward_substitution skyfs_checker u_skyfs_checker (.*);
